// ===== design/tdp_pkg.sv =====
// shared types and constants for the trial-division prime test
package tdp_pkg;

  localparam int WIDTH = 32;
  localparam int NW    = WIDTH - 1;        // magnitude bits of a non-negative value
  localparam int SQW   = NW + 2;           // running divisor square
  localparam int CW    = $clog2(NW);       // divider bit counter

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASS,
    ST_BOUND,
    ST_DIV,
    ST_TEST
  } state_t;

  typedef struct packed {
    logic load;       // latch a new value, divisor 3, square 9
    logic div_start;  // clear remainder, point at top bit
    logic div_step;   // one restoring division step
    logic next_div;   // move on to the next odd divisor
  } dp_cmd_t;

  typedef struct packed {
    logic neg;
    logic le1;
    logic lt4;
    logic even;
    logic sq_gt_n;
    logic div_last;
    logic rem_zero;
  } dp_sts_t;

endpackage

// ===== design/tdp_datapath.sv =====
// value, divisor, running square and bit-serial remainder unit
module tdp_datapath (
  input  logic                          clk,
  input  logic signed [tdp_pkg::WIDTH-1:0] in_number,
  input  tdp_pkg::dp_cmd_t              cmd,
  output tdp_pkg::dp_sts_t              sts
);
  import tdp_pkg::*;

  logic          neg_r, neg_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [NW-1:0] d_r, d_nxt;
  logic [SQW-1:0] sq_r, sq_nxt;
  logic [NW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW:0]   shifted;
  logic [NW:0]   diff;

  // shift in the next dividend bit and subtract when it fits
  assign shifted = {rem_r, n_r[cnt_r]};
  assign diff    = shifted - {1'b0, d_r};

  always_comb begin
    neg_nxt = neg_r;
    n_nxt   = n_r;
    d_nxt   = d_r;
    sq_nxt  = sq_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      neg_nxt = in_number[WIDTH-1];
      n_nxt   = in_number[NW-1:0];
      d_nxt   = NW'(3);
      sq_nxt  = SQW'(9);
    end
    if (cmd.div_start) begin
      rem_nxt = '0;
      cnt_nxt = CW'(NW - 1);
    end
    if (cmd.div_step) begin
      if (shifted >= {1'b0, d_r}) begin
        rem_nxt = diff[NW-1:0];
      end else begin
        rem_nxt = shifted[NW-1:0];
      end
      cnt_nxt = cnt_r - CW'(1);
    end
    if (cmd.next_div) begin
      // (d+2)^2 = d^2 + 4d + 4
      d_nxt  = d_r + NW'(2);
      sq_nxt = sq_r + {d_r, 2'b00} + SQW'(4);
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    sq_r  <= sq_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  always_comb begin
    sts.neg      = neg_r;
    sts.le1      = (n_r <= NW'(1));
    sts.lt4      = (n_r < NW'(4));
    sts.even     = ~n_r[0];
    sts.sq_gt_n  = (sq_r > {2'b00, n_r});
    sts.div_last = (cnt_r == '0);
    sts.rem_zero = (rem_r == '0);
  end

endmodule

// ===== design/tdp_ctrl.sv =====
// sequencing state machine and result register
module tdp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output logic             out_valid,
  output logic             out_prime_flag,
  output tdp_pkg::dp_cmd_t cmd,
  input  tdp_pkg::dp_sts_t sts
);
  import tdp_pkg::*;

  state_t state_r, state_nxt;
  logic   valid_r, valid_nxt;
  logic   flag_r, flag_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    flag_r <= flag_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    valid_nxt = 1'b0;
    flag_nxt  = flag_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CLASS;
        end
      end
      ST_CLASS: begin
        priority if (sts.neg || sts.le1) begin
          valid_nxt = 1'b1;
          flag_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end else if (sts.lt4) begin
          valid_nxt = 1'b1;
          flag_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end else if (sts.even) begin
          valid_nxt = 1'b1;
          flag_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_BOUND;
        end
      end
      ST_BOUND: begin
        if (sts.sq_gt_n) begin
          valid_nxt = 1'b1;
          flag_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        if (sts.rem_zero) begin
          valid_nxt = 1'b1;
          flag_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          cmd.next_div = 1'b1;
          state_nxt    = ST_BOUND;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = valid_r;
  assign out_prime_flag = flag_r;

endmodule

// ===== design/trial_division_prime_test.sv =====
// top level of the trial-division prime test
// negative, 0..3 and even values are settled by the classify step; each odd divisor tried
//   adds a bound check, a full division and a remainder test, up to the first that divides
//   or, for a prime, until the divisor square exceeds the value
// throughput: one value at a time; the next is taken in the cycle its result shows
// the receiver cannot stall; each result is a one-cycle beat on out_valid
// reset is synchronous, active low; it returns to idle and drops out_valid
module trial_division_prime_test (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [tdp_pkg::WIDTH-1:0] in_number,
  output logic                             out_valid,
  output logic                             out_prime_flag
);
  import tdp_pkg::*;

  // command and status between the sequencer and the datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // controller: classifies the value, bounds the divisor by its square,
  // runs one division of WIDTH-1 steps per divisor and emits the beat
  tdp_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .out_valid      (out_valid),
    .out_prime_flag (out_prime_flag),
    .cmd            (cmd),
    .sts            (sts)
  );

  // datapath: holds the value, the odd divisor, its square kept up by
  // adding 4d+4, and the restoring remainder that takes one bit a cycle
  tdp_datapath u_dp (
    .clk       (clk),
    .in_number (in_number),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== design/tdp_checker.sv =====
// port-level checks for the prime test, bound to the top level
module tdp_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);
  import tdp_pkg::*;

  // a result beat only shows once the block is back at idle
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while busy");

  // an accepted value makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted value did not start work");

  // leaving busy always delivers a result beat
  a_done_beat: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_valid)
    else $error("work ended without a result beat");

  // no stray beat without work just finished
  a_no_stray: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(rst_n)) |-> $past(busy))
    else $error("result beat without work");

endmodule

bind trial_division_prime_test tdp_checker u_tdp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
